// File: src/pbe_pkg.sv
// types and constants shared by the packbits encoder modules
package pbe_pkg;

   localparam int unsigned RES_MAX = 4;
   localparam logic [7:0] GROUP_MAX = 8'd128;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_LIT,
      MODE_RUN
   } mode_type;

   // encoder state carried from one byte to the next
   typedef struct packed {
      logic [7:0]  held_byte;
      logic        held_valid;
      mode_type    mode;
      logic [7:0]  run_value;
      logic [7:0]  run_count;
      logic [7:0]  literal_count;
      logic [15:0] header_slot;
      logic [15:0] write_pointer;
   } state_type;

   // one output memory write
   typedef struct packed {
      logic [15:0] write_offset;
      logic [7:0]  write_byte;
      logic        final_write;
      logic [15:0] total_length;
      logic        too_long;
   } res_type;

   // all writes caused by one input byte
   typedef struct packed {
      logic [2:0]                count;
      res_type [RES_MAX-1:0]     res;
   } batch_type;

endpackage

// File: src/packbits_encoder_unit.sv
// top level of the packbits run-length encoder
//
// usage:
//  - req channel: one uncompressed byte per transaction, req_last_byte high
//    on the final byte of a buffer; a buffer is never empty
//  - rsp channel: addressed writes into the compressed output memory; a
//    literal header is written back to its reserved slot when its group closes
//  - the last write of a buffer has rsp_final_write high and carries the
//    compressed length; an over-long buffer ends in one write with
//    rsp_too_long high and nothing else written for it
//  - a byte is held in the input register until the result bank can take its
//    writes, which are then loaded into the bank and handed out from there
//  - throughput: one byte per cycle when it causes at most one write and
//    rsp_stall stays low; a byte causing more writes holds the input until
//    the single write port of the result bank has handed them all out
//  - reset clears the encoder state, the input register and the result bank;
//    the next buffer starts at offset 0
//  - rsp_stall holds the current write; the input register still takes one
//    more transaction, then req_stall rises until the bank frees up
module packbits_encoder_unit #(
   parameter int unsigned MAX_INPUT_LEN = 32768
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_write_offset,
   output logic [7:0]  rsp_write_byte,
   output logic        rsp_final_write,
   output logic [15:0] rsp_total_length,
   output logic        rsp_too_long
);

   // byte counter saturates one past the bound
   localparam int unsigned CNT_W = $clog2(MAX_INPUT_LEN + 2);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // encoder state
   pbe_pkg::state_type st_ff, st_in;
   logic [CNT_W-1:0]   seen_ff, seen_in;

   pbe_pkg::batch_type batch;
   logic               bank_free;
   logic               in_take;
   logic               req_fire;

   // an item is processed once the result bank can take all its writes
   assign in_take   = in_valid_ff && bank_free;
   assign req_stall = in_valid_ff && !bank_free;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         st_ff       <= '0;
         seen_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (in_take) begin
            st_ff   <= st_in;
            seen_ff <= seen_in;
         end
      end
   end

   // payload of the input register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // classify the byte and build its list of writes
   pbe_step #(
      .MAX_INPUT_LEN (MAX_INPUT_LEN),
      .CNT_W         (CNT_W)
   ) u_step (
      .st_cur    (st_ff),
      .seen_cur  (seen_ff),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .st_next   (st_in),
      .seen_next (seen_in),
      .batch     (batch)
   );

   // hand the writes out one per transaction
   pbe_out_stage u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (in_take),
      .batch            (batch),
      .free             (bank_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_write_offset (rsp_write_offset),
      .rsp_write_byte   (rsp_write_byte),
      .rsp_final_write  (rsp_final_write),
      .rsp_total_length (rsp_total_length),
      .rsp_too_long     (rsp_too_long)
   );

endmodule

// File: src/pbe_step.sv
// combinational packbits step: state and one byte in, next state and writes out
module pbe_step #(
   parameter int unsigned MAX_INPUT_LEN = 32768,
   parameter int unsigned CNT_W = $clog2(MAX_INPUT_LEN + 2)
) (
   input  pbe_pkg::state_type st_cur,
   input  logic [CNT_W-1:0]   seen_cur,
   input  logic [7:0]         data_byte,
   input  logic               last_byte,
   output pbe_pkg::state_type st_next,
   output logic [CNT_W-1:0]   seen_next,
   output pbe_pkg::batch_type batch
);

   localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_INPUT_LEN);

   typedef struct packed {
      pbe_pkg::state_type                     st;
      pbe_pkg::res_type [pbe_pkg::RES_MAX-1:0] res;
      logic [2:0]                             n;
   } ctx_type;

   function automatic ctx_type emit(ctx_type c, logic [15:0] off, logic [7:0] b);
      ctx_type o;
      o = c;
      if (o.n < 3'(pbe_pkg::RES_MAX)) begin
         o.res[o.n[1:0]].write_offset = off;
         o.res[o.n[1:0]].write_byte   = b;
         o.res[o.n[1:0]].final_write  = 1'b0;
         o.res[o.n[1:0]].total_length = 16'd0;
         o.res[o.n[1:0]].too_long     = 1'b0;
         o.n = o.n + 3'd1;
      end
      return o;
   endfunction

   function automatic ctx_type lit_close(ctx_type c);
      ctx_type o;
      o = c;
      if (o.st.mode == pbe_pkg::MODE_LIT) begin
         o = emit(o, o.st.header_slot, o.st.literal_count - 8'd1);
         o.st.mode = pbe_pkg::MODE_IDLE;
         o.st.literal_count = 8'd0;
      end
      return o;
   endfunction

   function automatic ctx_type lit_push(ctx_type c, logic [7:0] b);
      ctx_type o;
      o = c;
      // open a group: reserve the header slot
      if (o.st.mode != pbe_pkg::MODE_LIT) begin
         o.st.header_slot   = o.st.write_pointer;
         o.st.write_pointer = o.st.write_pointer + 16'd1;
         o.st.literal_count = 8'd0;
         o.st.mode          = pbe_pkg::MODE_LIT;
      end
      o = emit(o, o.st.write_pointer, b);
      o.st.write_pointer = o.st.write_pointer + 16'd1;
      o.st.literal_count = o.st.literal_count + 8'd1;
      if (o.st.literal_count >= pbe_pkg::GROUP_MAX) begin
         o = lit_close(o);
      end
      return o;
   endfunction

   function automatic ctx_type run_close(ctx_type c);
      ctx_type o;
      o = c;
      o = emit(o, o.st.write_pointer, 8'd1 - o.st.run_count);
      o.st.write_pointer = o.st.write_pointer + 16'd1;
      o = emit(o, o.st.write_pointer, o.st.run_value);
      o.st.write_pointer = o.st.write_pointer + 16'd1;
      o.st.mode      = pbe_pkg::MODE_IDLE;
      o.st.run_count = 8'd0;
      return o;
   endfunction

   ctx_type          c;
   logic [CNT_W-1:0] seen_v;

   always_comb begin
      c      = '0;
      c.st   = st_cur;
      seen_v = seen_cur;
      if (seen_v <= MAX_C) begin
         seen_v = seen_v + CNT_W'(1);
      end
      if (seen_v > MAX_C) begin
         // over-long buffer: drop bytes, report the error on the last one
         if (last_byte) begin
            c.res[0].final_write = 1'b1;
            c.res[0].too_long    = 1'b1;
            c.n    = 3'd1;
            c.st   = '0;
            seen_v = '0;
         end
      end else begin
         if (c.st.mode == pbe_pkg::MODE_RUN) begin
            if (data_byte == c.st.run_value) begin
               c.st.run_count = c.st.run_count + 8'd1;
               if (c.st.run_count >= pbe_pkg::GROUP_MAX || last_byte) begin
                  c = run_close(c);
               end
            end else begin
               c = run_close(c);
               c.st.held_byte  = data_byte;
               c.st.held_valid = 1'b1;
            end
         end else if (c.st.held_valid) begin
            if (data_byte == c.st.held_byte) begin
               c = lit_close(c);
               c.st.mode       = pbe_pkg::MODE_RUN;
               c.st.run_value  = data_byte;
               c.st.run_count  = 8'd2;
               c.st.held_valid = 1'b0;
               if (last_byte) begin
                  c = run_close(c);
               end
            end else begin
               c = lit_push(c, c.st.held_byte);
               c.st.held_byte = data_byte;
            end
         end else begin
            c.st.held_byte  = data_byte;
            c.st.held_valid = 1'b1;
         end

         if (last_byte) begin
            if (c.st.held_valid) begin
               c = lit_push(c, c.st.held_byte);
               c.st.held_valid = 1'b0;
            end
            c = lit_close(c);
            if (c.n != 3'd0) begin
               c.res[2'(c.n - 3'd1)].final_write  = 1'b1;
               c.res[2'(c.n - 3'd1)].total_length = c.st.write_pointer;
            end
            c.st   = '0;
            seen_v = '0;
         end
      end
   end

   assign st_next     = c.st;
   assign seen_next   = seen_v;
   assign batch.count = c.n;
   assign batch.res   = c.res;

endmodule

// File: src/pbe_out_stage.sv
// result register bank that hands out one byte's writes one per cycle while rsp_stall is low
module pbe_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  pbe_pkg::batch_type batch,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_write_offset,
   output logic [7:0]         rsp_write_byte,
   output logic               rsp_final_write,
   output logic [15:0]        rsp_total_length,
   output logic               rsp_too_long
);

   pbe_pkg::res_type [pbe_pkg::RES_MAX-1:0] ent_ff;
   logic [2:0] rem_ff, rem_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_fire;

   assign rsp_valid = (rem_ff != 3'd0);
   assign out_fire  = rsp_valid && !rsp_stall;
   assign free      = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && out_fire);

   always_comb begin
      rem_in = rem_ff;
      idx_in = idx_ff;
      if (load) begin
         rem_in = batch.count;
         idx_in = 2'd0;
      end else if (out_fire) begin
         rem_in = rem_ff - 3'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff <= batch.res;
      end
   end

   assign rsp_write_offset = ent_ff[idx_ff].write_offset;
   assign rsp_write_byte   = ent_ff[idx_ff].write_byte;
   assign rsp_final_write  = ent_ff[idx_ff].final_write;
   assign rsp_total_length = ent_ff[idx_ff].total_length;
   assign rsp_too_long     = ent_ff[idx_ff].too_long;

endmodule

// File: src/pbe_checker.sv
// port-level checks for the packbits encoder, bound to the top level
module pbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_write_offset,
   input logic [7:0]  rsp_write_byte,
   input logic        rsp_final_write,
   input logic [15:0] rsp_total_length,
   input logic        rsp_too_long
);

   // an error report always ends its buffer
   a_err_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_final_write)
      else $error("too_long without final_write");

   // error report carries no offset and no length
   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_write_offset == 16'd0 && rsp_total_length == 16'd0)
      else $error("too_long with nonzero offset or length");

   // length only on the final write
   a_len_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_write |-> rsp_total_length == 16'd0)
      else $error("total_length on a non-final write");

   // a stalled write stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_write_offset)
         && $stable(rsp_write_byte))
      else $error("stalled write changed");

   // a stalled byte stays offered and unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data_byte)
         && $stable(req_last_byte))
      else $error("stalled byte changed");

endmodule

bind packbits_encoder_unit pbe_checker u_pbe_checker (.*);

// File: test/tb_packbits_encoder_unit.sv
// testbench for the packbits encoder: byte stimulus, write prediction and checking
`timescale 1ns / 1ps

module tb_packbits_encoder_unit;

   localparam int unsigned MAX_LEN      = 32768;
   localparam int unsigned RANDOM_ITEMS = 30;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_LIMIT  = 200000;

   // predicts the memory writes of each accepted byte and checks them in order
   class write_scoreboard;
      logic [7:0]        held_byte;
      bit                held_valid;
      pbe_pkg::mode_type mode;
      logic [7:0]        run_value;
      logic [7:0]        run_count;
      logic [7:0]        lit_count;
      logic [15:0]       hdr_slot;
      logic [15:0]       wr_ptr;
      int unsigned       bytes_in;
      pbe_pkg::res_type  step_writes[$];
      pbe_pkg::res_type  expected_writes[$];
      int unsigned       failures;

      function void restart();
         held_byte  = '0;
         held_valid = 1'b0;
         mode       = pbe_pkg::MODE_IDLE;
         run_value  = '0;
         run_count  = '0;
         lit_count  = '0;
         hdr_slot   = '0;
         wr_ptr     = '0;
         bytes_in   = 0;
      endfunction

      function void emit_write(input logic [15:0] off, input logic [7:0] b);
         pbe_pkg::res_type w;
         w = '0;
         w.write_offset = off;
         w.write_byte   = b;
         if (step_writes.size() < pbe_pkg::RES_MAX) step_writes.push_back(w);
      endfunction

      // write back the reserved header of an open literal group
      function void close_literal();
         if (mode == pbe_pkg::MODE_LIT) begin
            emit_write(hdr_slot, lit_count - 8'd1);
            mode      = pbe_pkg::MODE_IDLE;
            lit_count = '0;
         end
      endfunction

      function void push_literal(input logic [7:0] b);
         if (mode != pbe_pkg::MODE_LIT) begin
            hdr_slot  = wr_ptr;
            wr_ptr    = wr_ptr + 16'd1;
            lit_count = '0;
            mode      = pbe_pkg::MODE_LIT;
         end
         emit_write(wr_ptr, b);
         wr_ptr    = wr_ptr + 16'd1;
         lit_count = lit_count + 8'd1;
         if (lit_count >= pbe_pkg::GROUP_MAX) close_literal();
      endfunction

      function void close_run();
         emit_write(wr_ptr, 8'd1 - run_count);
         wr_ptr = wr_ptr + 16'd1;
         emit_write(wr_ptr, run_value);
         wr_ptr    = wr_ptr + 16'd1;
         mode      = pbe_pkg::MODE_IDLE;
         run_count = '0;
      endfunction

      function void note_byte(input logic [7:0] x, input logic last);
         pbe_pkg::res_type w;
         step_writes.delete();
         if (bytes_in <= MAX_LEN) bytes_in++;
         // over-long buffer: bytes dropped, one error write on the last byte
         if (bytes_in > MAX_LEN) begin
            if (last) begin
               w = '0;
               w.final_write = 1'b1;
               w.too_long    = 1'b1;
               expected_writes.push_back(w);
               restart();
            end
            return;
         end
         if (mode == pbe_pkg::MODE_RUN) begin
            if (x == run_value) begin
               run_count = run_count + 8'd1;
               if (run_count >= pbe_pkg::GROUP_MAX || last) close_run();
            end else begin
               close_run();
               held_byte  = x;
               held_valid = 1'b1;
            end
         end else if (held_valid) begin
            if (x == held_byte) begin
               close_literal();
               mode       = pbe_pkg::MODE_RUN;
               run_value  = x;
               run_count  = 8'd2;
               held_valid = 1'b0;
               if (last) close_run();
            end else begin
               push_literal(held_byte);
               held_byte = x;
            end
         end else begin
            held_byte  = x;
            held_valid = 1'b1;
         end
         if (last) begin
            if (held_valid) begin
               push_literal(held_byte);
               held_valid = 1'b0;
            end
            close_literal();
            if (step_writes.size() > 0) begin
               w = step_writes.pop_back();
               w.final_write  = 1'b1;
               w.total_length = wr_ptr;
               step_writes.push_back(w);
            end
            restart();
         end
         foreach (step_writes[i]) expected_writes.push_back(step_writes[i]);
      endfunction

      function void compare_field(input string name, input logic [15:0] want,
                                  input logic [15:0] got);
         if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_write(input pbe_pkg::res_type got);
         pbe_pkg::res_type want;
         if (expected_writes.size() == 0) begin
            failures++;
            $display("%0t: unexpected write, expected none, actual offset %0d byte %0d",
                     $time, got.write_offset, got.write_byte);
            return;
         end
         want = expected_writes.pop_front();
         compare_field("write_offset", want.write_offset, got.write_offset);
         compare_field("write_byte", 16'(want.write_byte), 16'(got.write_byte));
         compare_field("final_write", 16'(want.final_write), 16'(got.final_write));
         compare_field("total_length", want.total_length, got.total_length);
         compare_field("too_long", 16'(want.too_long), 16'(got.too_long));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_write_offset;
   logic [7:0]  rsp_write_byte;
   logic        rsp_final_write;
   logic [15:0] rsp_total_length;
   logic        rsp_too_long;

   write_scoreboard  sb;
   pbe_pkg::res_type observed;
   logic [7:0]       stim_bytes[$];
   int unsigned      burst_left = 0;
   bit               hold_req = 1'b0;

   packbits_encoder_unit #(
      .MAX_INPUT_LEN(MAX_LEN)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_write_offset(rsp_write_offset),
      .rsp_write_byte(rsp_write_byte),
      .rsp_final_write(rsp_final_write),
      .rsp_total_length(rsp_total_length),
      .rsp_too_long(rsp_too_long)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #24_000_000;
      $display("packbits_encoder_unit verification failed");
      $finish;
   end

   // receiver: changing stall styles, plus a long hold-off on request
   initial begin
      int unsigned style_left;
      int unsigned stall_style;
      int unsigned hold_left;
      bit          toggle;
      bit          s;
      style_left = 0;
      stall_style = 0;
      hold_left = 0;
      toggle = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(20, 200);
         end
         style_left--;
         case (stall_style)
            0: s = 1'b0;
            1: s = ($urandom_range(0, 7) == 0);
            2: s = 1'($urandom_range(0, 1));
            default: begin
               toggle = ~toggle;
               s = toggle;
            end
         endcase
         if (hold_left > 0) begin
            s = 1'b1;
            hold_left--;
         end
         rsp_stall <= s;
      end
   end

   // every write taken on the rsp channel goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         observed.write_offset = rsp_write_offset;
         observed.write_byte   = rsp_write_byte;
         observed.final_write  = rsp_final_write;
         observed.total_length = rsp_total_length;
         observed.too_long     = rsp_too_long;
         sb.check_write(observed);
      end
   end

   // offer one byte, in bursts with random gaps, and wait for the transaction
   task automatic send_byte(input logic [7:0] d, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      sb.note_byte(d, last);
   endtask

   task automatic send_buffer();
      foreach (stim_bytes[i]) send_byte(stim_bytes[i], i == stim_bytes.size() - 1);
      stim_bytes.delete();
   endtask

   // sender pause until every write has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (sb.expected_writes.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic add_run(input logic [7:0] v, input int unsigned n);
      repeat (n) stim_bytes.push_back(v);
   endtask

   // bytes with no two equal neighbours
   task automatic add_literal(input int unsigned n);
      logic [7:0] prev;
      prev = (stim_bytes.size() > 0) ? stim_bytes[$] : 8'($urandom_range(0, 255));
      repeat (n) begin
         prev = prev + 8'($urandom_range(1, 255));
         stim_bytes.push_back(prev);
      end
   endtask

   // mix of runs, literals and near-repeats from a two-value alphabet
   task automatic add_mixed(input int unsigned n);
      int unsigned target;
      int unsigned kind;
      logic [7:0]  base;
      target = stim_bytes.size() + n;
      while (stim_bytes.size() < target) begin
         kind = $urandom_range(0, 9);
         base = 8'($urandom_range(0, 255));
         if (kind <= 3) begin
            add_run(base, $urandom_range(2, 6));
         end else if (kind <= 6) begin
            add_literal($urandom_range(1, 5));
         end else if (kind <= 8) begin
            repeat ($urandom_range(1, 6)) stim_bytes.push_back(base ^ 8'($urandom_range(0, 1)));
         end else begin
            add_run(base, (n >= 100) ? $urandom_range(100, 140) : $urandom_range(2, 3));
         end
      end
      while (stim_bytes.size() > target) void'(stim_bytes.pop_back());
   endtask

   initial begin
      int unsigned rand_items;
      int unsigned len;
      int unsigned waited;
      rand_items = 0;
      sb = new();
      sb.restart();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short buffers: single bytes at both extremes, pairs, runs inside literals
      stim_bytes = '{8'h00};
      send_buffer();
      stim_bytes = '{8'hff};
      send_buffer();
      stim_bytes = '{8'haa, 8'haa};
      send_buffer();
      stim_bytes = '{8'h00, 8'hff};
      send_buffer();
      stim_bytes = '{8'h12, 8'h34, 8'h34, 8'h34, 8'h56};
      send_buffer();
      // open run closed by a different last byte: four writes from one byte
      stim_bytes = '{8'h07, 8'h07, 8'h07, 8'h80};
      send_buffer();
      stim_bytes = '{8'h01, 8'h02, 8'h01, 8'h02};
      send_buffer();
      stim_bytes = '{8'h55, 8'h55, 8'haa, 8'haa};
      send_buffer();
      wait_for_drain();

      // group size limits, offered while the receiver holds off so the input backs up
      hold_req = 1'b1;
      add_literal(129);
      send_buffer();
      add_run(8'hc3, 129);
      send_buffer();
      wait_for_drain();

      // random short buffers
      while (rand_items < RANDOM_ITEMS) begin
         len = $urandom_range(1, 12);
         add_mixed(len);
         send_buffer();
         rand_items += len;
      end
      req_valid <= 1'b0;

      waited = 0;
      while (sb.expected_writes.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (16) @(posedge clock);
      if (sb.expected_writes.size() > 0)
         $display("%0t: %0d expected writes never arrived", $time, sb.expected_writes.size());
      if (sb.failures == 0 && sb.expected_writes.size() == 0) begin
         $display("packbits_encoder_unit verification clean");
      end else begin
         $display("packbits_encoder_unit verification failed");
      end
      $finish;
   end

endmodule
